@@ rtl/ramr_pkg.sv @@
`default_nettype none
package ramr_pkg;

    localparam int unsigned FieldW = 32;
    localparam int unsigned WideW  = 64;
    localparam int unsigned DenW   = 31;

    // Operation selector on the input tuser
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_MUL = 1'b1;

    // Which reduction the shared gcd/divide unit is working on
    typedef enum logic [1:0] {
        PH_A   = 2'd0,
        PH_B   = 2'd1,
        PH_LCD = 2'd2,
        PH_RES = 2'd3
    } phase_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RED  = 7'b0000010,
        ST_GCD  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_NXT  = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    // Magnitude of a 32-bit two's complement value
    function automatic logic [FieldW-1:0] mag32(input logic [FieldW-1:0] v);
        mag32 = v[FieldW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rational_add_multiply_reduce.sv @@
// Rational add / multiply with reduction.
//
// Input channel (s_*): one item holds two fractions a_num/a_den and b_num/b_den
// in s_tdata and the operation in s_tuser (0 add, 1 multiply). Result channel
// (m_*): the reduced fraction in m_tdata, the overflow flag in m_tuser. Each
// operand is reduced, then combined (least common denominator for add), then
// the result is reduced; a zero numerator or denominator gives 0/1, and a
// result that does not fit gives 0/1 with overflow set.
//
// One item is worked on at a time; s_tready is high only while idle, so the
// next item is taken no earlier than the cycle after the result is accepted.
// The work per item depends on the data: three reductions for multiply, four
// for add, each a binary gcd (one subtract or shift a cycle) and two 64-bit
// bit-serial divisions, plus two products (multiply) or three (add) on a
// single shared 32x32 multiplier; a zero part skips the gcd and the divisions
// of its reduction.
//
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_tvalid. When the receiver stalls, the result stays on m_tdata/m_tuser and
// no new item is taken until it is accepted.
`default_nettype none
module rational_add_multiply_reduce
    import ramr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    input  wire logic [127:0] s_tdata,
    // func [0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // res_num [31:0], res_den [62:32], zero pad [63]
    output logic [63:0]       m_tdata,
    // overflow [0]
    output logic              m_tuser
);

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic               func_reg, func_next;
    logic [FieldW-1:0]  bn_raw_reg, bn_raw_next, bd_raw_reg, bd_raw_next;
    logic [FieldW-1:0]  am_reg, am_next, ad_reg, ad_next;
    logic [FieldW-1:0]  bm_reg, bm_next, bd_reg, bd_next;
    logic [FieldW-1:0]  q1_reg, q1_next, q2_reg, q2_next;
    logic               aneg_reg, aneg_next, bneg_reg, bneg_next;
    logic               cneg_reg, cneg_next;
    logic [WideW-1:0]   x_reg, x_next, y_reg, y_next;
    logic [WideW-1:0]   u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [5:0]         k_reg, k_next;
    logic [WideW-1:0]   dvd_reg, dvd_next, qx_reg, qx_next, qy_reg, qy_next;
    logic [WideW:0]     rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               sel_reg, sel_next;
    logic [1:0]         mstep_reg, mstep_next;
    logic [WideW-1:0]   t1_reg, t1_next, lcd_reg, lcd_next;
    logic               mvalid_reg, mvalid_next;
    logic [63:0]        mdata_reg, mdata_next;
    logic               movf_reg, movf_next;

    logic [FieldW-1:0]  mul_a, mul_b;
    logic [WideW-1:0]   mul_p;
    logic [WideW:0]     div_sh;
    logic [WideW-1:0]   limit;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = movf_reg;

    // Shared multiplier operand selection
    always_comb begin
        mul_a = am_reg;
        mul_b = bm_reg;
        if (func_reg == FUNC_MUL) begin
            if (mstep_reg != 2'd0) begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        end else begin
            unique case (mstep_reg)
                2'd0: begin mul_a = q1_reg; mul_b = bd_reg; end
                2'd1: begin mul_a = am_reg; mul_b = q2_reg; end
                default: begin mul_a = bm_reg; mul_b = q1_reg; end
            endcase
        end
    end
    assign mul_p  = WideW'(mul_a) * WideW'(mul_b);
    assign div_sh = {rem_reg[WideW-1:0], dvd_reg[WideW-1]};
    assign limit  = cneg_reg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;

    // Sequencer
    always_comb begin
        state_next  = state_reg;   phase_next  = phase_reg;   func_next  = func_reg;
        bn_raw_next = bn_raw_reg;  bd_raw_next = bd_raw_reg;
        am_next = am_reg; ad_next = ad_reg; bm_next = bm_reg; bd_next = bd_reg;
        q1_next = q1_reg; q2_next = q2_reg;
        aneg_next = aneg_reg; bneg_next = bneg_reg; cneg_next = cneg_reg;
        x_next = x_reg; y_next = y_reg; u_next = u_reg; v_next = v_reg; g_next = g_reg;
        k_next = k_reg; dvd_next = dvd_reg; qx_next = qx_reg; qy_next = qy_reg;
        rem_next = rem_reg; cnt_next = cnt_reg; sel_next = sel_reg;
        mstep_next = mstep_reg;
        t1_next = t1_reg; lcd_next = lcd_reg;
        mvalid_next = mvalid_reg; mdata_next = mdata_reg; movf_next = movf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // Take an item and start on the first operand
                if (s_tvalid) begin
                    func_next   = s_tuser;
                    bn_raw_next = s_tdata[95:64];
                    bd_raw_next = s_tdata[127:96];
                    x_next      = WideW'(mag32(s_tdata[31:0]));
                    y_next      = WideW'(mag32(s_tdata[63:32]));
                    cneg_next   = s_tdata[31] ^ s_tdata[63];
                    phase_next  = PH_A;
                    state_next  = ST_RED;
                end
            end
            ST_RED: begin
                // Zero in either part gives 0/1 directly
                if (x_reg == '0 || y_reg == '0) begin
                    qx_next    = '0;
                    qy_next    = WideW'(1);
                    cneg_next  = 1'b0;
                    state_next = ST_NXT;
                end else begin
                    u_next     = x_reg;
                    v_next     = y_reg;
                    k_next     = '0;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                // Binary gcd, one shift or subtract a cycle
                if (u_reg == '0 || v_reg == '0) begin
                    g_next     = (u_reg | v_reg) << k_reg;
                    dvd_next   = x_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    sel_next   = 1'b0;
                    state_next = ST_DIV;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 6'd1;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (u_reg >= v_reg) begin
                    u_next = u_reg - v_reg;
                end else begin
                    v_next = v_reg - u_reg;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit a cycle
                if (div_sh >= {1'b0, g_reg}) begin
                    rem_next = div_sh - {1'b0, g_reg};
                    dvd_next = {dvd_reg[WideW-2:0], 1'b1};
                end else begin
                    rem_next = div_sh;
                    dvd_next = {dvd_reg[WideW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    if (!sel_reg) begin
                        qx_next  = dvd_next;
                        dvd_next = y_reg;
                        rem_next = '0;
                        sel_next = 1'b1;
                    end else begin
                        qy_next    = dvd_next;
                        state_next = ST_NXT;
                    end
                end
            end
            ST_NXT: begin
                // Store the reduced pair and move on to the next reduction, the products or the output
                unique case (phase_reg)
                    PH_A: begin
                        am_next    = qx_reg[FieldW-1:0];
                        ad_next    = qy_reg[FieldW-1:0];
                        aneg_next  = cneg_reg;
                        x_next     = WideW'(mag32(bn_raw_reg));
                        y_next     = WideW'(mag32(bd_raw_reg));
                        cneg_next  = bn_raw_reg[FieldW-1] ^ bd_raw_reg[FieldW-1];
                        phase_next = PH_B;
                        state_next = ST_RED;
                    end
                    PH_B: begin
                        bm_next    = qx_reg[FieldW-1:0];
                        bd_next    = qy_reg[FieldW-1:0];
                        bneg_next  = cneg_reg;
                        mstep_next = '0;
                        if (func_reg == FUNC_MUL) begin
                            state_next = ST_MUL;
                        end else begin
                            x_next     = WideW'(ad_reg);
                            y_next     = WideW'(qy_reg[FieldW-1:0]);
                            phase_next = PH_LCD;
                            state_next = ST_RED;
                        end
                    end
                    PH_LCD: begin
                        q1_next    = qx_reg[FieldW-1:0];
                        q2_next    = qy_reg[FieldW-1:0];
                        state_next = ST_MUL;
                    end
                    default: begin
                        // Range check of the final reduced fraction
                        mvalid_next = 1'b1;
                        if (qx_reg > limit || qy_reg > WideW'(32'h7FFF_FFFF)) begin
                            mdata_next = 64'h0000_0001_0000_0000;
                            movf_next  = 1'b1;
                        end else begin
                            mdata_next = {1'b0, qy_reg[DenW-1:0],
                                          cneg_reg ? (~qx_reg[FieldW-1:0] + 1'b1)
                                                   : qx_reg[FieldW-1:0]};
                            movf_next  = 1'b0;
                        end
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_MUL: begin
                // One product a cycle, then combine for the last reduction
                mstep_next = mstep_reg + 2'd1;
                if (func_reg == FUNC_MUL) begin
                    if (mstep_reg == 2'd0) begin
                        t1_next = mul_p;
                    end else begin
                        x_next     = t1_reg;
                        y_next     = mul_p;
                        cneg_next  = aneg_reg ^ bneg_reg;
                        phase_next = PH_RES;
                        state_next = ST_RED;
                    end
                end else begin
                    if (mstep_reg == 2'd0) begin
                        lcd_next = mul_p;
                    end else if (mstep_reg == 2'd1) begin
                        t1_next = mul_p;
                    end else begin
                        y_next  = lcd_reg;
                        if (aneg_reg == bneg_reg) begin
                            x_next    = t1_reg + mul_p;
                            cneg_next = aneg_reg;
                        end else if (t1_reg >= mul_p) begin
                            x_next    = t1_reg - mul_p;
                            cneg_next = aneg_reg;
                        end else begin
                            x_next    = mul_p - t1_reg;
                            cneg_next = bneg_reg;
                        end
                        phase_next = PH_RES;
                        state_next = ST_RED;
                    end
                end
            end
            default: begin
                // Hold the result until taken
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        phase_reg <= phase_next;   func_reg <= func_next;
        bn_raw_reg <= bn_raw_next; bd_raw_reg <= bd_raw_next;
        am_reg <= am_next; ad_reg <= ad_next; bm_reg <= bm_next; bd_reg <= bd_next;
        q1_reg <= q1_next; q2_reg <= q2_next;
        aneg_reg <= aneg_next; bneg_reg <= bneg_next; cneg_reg <= cneg_next;
        x_reg <= x_next; y_reg <= y_next; u_reg <= u_next; v_reg <= v_next;
        g_reg <= g_next; k_reg <= k_next;
        dvd_reg <= dvd_next; qx_reg <= qx_next; qy_reg <= qy_next;
        rem_reg <= rem_next; cnt_reg <= cnt_next; sel_reg <= sel_next;
        mstep_reg <= mstep_next;
        t1_reg <= t1_next; lcd_reg <= lcd_next;
        mdata_reg <= mdata_next; movf_reg <= movf_next;
    end

    // No new item is taken while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input ready while result pending");

    // An overflowed result is always 0/1
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 64'h0000_0001_0000_0000))
        else $error("overflow result not 0/1");

    // The delivered denominator is never zero
    a_den_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[62:32] != '0)) else $error("zero denominator");

    // The divider is only entered with a nonzero divisor
    a_div_g: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (g_reg != '0)) else $error("divide by zero");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ramr_pkg::*;

    localparam int unsigned StallLimit = 20000;

    typedef struct {
        logic        func;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
        bit          drain;
    } frac_pair_t;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic        ovf;
    } frac_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    frac_pair_t   pending_items[$];
    frac_result_t expected_fracs[$];
    int unsigned  error_count  = 0;
    int unsigned  result_count = 0;
    int unsigned  ovf_count    = 0;
    int unsigned  idle_cycles  = 0;
    int unsigned  cycle_count  = 0;
    int unsigned  burst_left   = 4;
    int unsigned  gap_left     = 0;
    int unsigned  stall_mode   = 0;
    bit           stim_done    = 1'b0;

    rational_add_multiply_reduce DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduce sign/magnitude/denominator; zero on either side gives 0/1
    function automatic void reduce_frac(input bit neg, input logic [63:0] mag,
                                        input logic [63:0] den,
                                        output bit rneg, output logic [63:0] rmag,
                                        output logic [63:0] rden);
        logic [63:0] g;
        if (mag == 0 || den == 0) begin
            rneg = 1'b0;
            rmag = '0;
            rden = 64'd1;
        end else begin
            g = euclid_gcd(mag, den);
            rneg = neg;
            rmag = mag / g;
            rden = den / g;
        end
    endfunction

    function automatic logic [63:0] abs32(input logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    function automatic frac_result_t combine_fracs(input frac_pair_t it);
        bit           an, bn, rn;
        logic [63:0]  am, ad, bm, bd, rm, rd, g, t1, t2, lcd, lim;
        frac_result_t r;
        reduce_frac(it.a_num[31] ^ it.a_den[31], abs32(it.a_num), abs32(it.a_den), an, am, ad);
        reduce_frac(it.b_num[31] ^ it.b_den[31], abs32(it.b_num), abs32(it.b_den), bn, bm, bd);
        if (it.func == FUNC_MUL) begin
            reduce_frac(an ^ bn, am * bm, ad * bd, rn, rm, rd);
        end else begin
            g   = euclid_gcd(ad, bd);
            lcd = (ad / g) * bd;
            t1  = am * (bd / g);
            t2  = bm * (ad / g);
            if (an == bn) reduce_frac(an, t1 + t2, lcd, rn, rm, rd);
            else if (t1 >= t2) reduce_frac(an, t1 - t2, lcd, rn, rm, rd);
            else reduce_frac(bn, t2 - t1, lcd, rn, rm, rd);
        end
        lim = rn ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (rm > lim || rd > 64'h7FFF_FFFF) begin
            r.num = '0;
            r.den = 31'd1;
            r.ovf = 1'b1;
        end else begin
            r.num = rn ? (32'd0 - rm[31:0]) : rm[31:0];
            r.den = rd[30:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_field();
        logic [31:0] specials[8];
        specials = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFE, 32'h8000_0001, 32'h4000_0000};
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3, 4:    return 32'($signed($urandom_range(0, 200)) - 100);
            5:       return specials[$urandom_range(0, 7)];
            6:       return $urandom() & 32'h8000_FFFF;
            // products of small primes so reduction does real work
            7, 8:    return 32'((2 ** $urandom_range(0, 8)) * (3 ** $urandom_range(0, 5)) *
                                (5 ** $urandom_range(0, 3)) * (7 ** $urandom_range(0, 2))) *
                            ($urandom_range(0, 1) ? -32'sd1 : 32'sd1);
            default: return 32'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic add_item(input logic f, input logic [31:0] an, input logic [31:0] ad,
                            input logic [31:0] bn, input logic [31:0] bd,
                            input bit dr = 1'b0);
        frac_pair_t it;
        it = '{f, an, ad, bn, bd, dr};
        pending_items.push_back(it);
    endtask

    // Fill the queue: directed corners first, then random items
    initial begin
        logic f;
        add_item(FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        add_item(FUNC_MUL, 32'd2, 32'd3, 32'd3, 32'd4);
        add_item(FUNC_ADD, 32'd0, 32'd5, 32'd7, 32'd9);
        add_item(FUNC_MUL, 32'd7, 32'd0, 32'd3, 32'd5);
        add_item(FUNC_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
        add_item(FUNC_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
        add_item(FUNC_ADD, 32'd1, 32'd2, -32'd1, 32'd2);
        add_item(FUNC_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        add_item(FUNC_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
        add_item(FUNC_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        add_item(FUNC_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        add_item(FUNC_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
        add_item(FUNC_ADD, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
        add_item(FUNC_MUL, 32'd1, 32'h8000_0000, 32'd2, 32'd1);
        add_item(FUNC_MUL, 32'd3, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        add_item(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        add_item(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_item(FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(FUNC_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        add_item(FUNC_ADD, 32'd6, -32'd4, -32'd9, 32'd6);
        add_item(FUNC_MUL, -32'd12, -32'd18, 32'd0, -32'd3);
        // wait for the pipeline to empty before the random part
        add_item(FUNC_ADD, 32'd5, 32'd10, 32'd3, 32'd9, 1'b1);
        for (int i = 0; i < 500; i++) begin
            f = $urandom_range(0, 1) ? FUNC_MUL : FUNC_ADD;
            add_item(f, rand_field(), rand_field(), rand_field(), rand_field(),
                     (i % 125) == 124);
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: present queued items in bursts with random gaps
    always @(posedge aclk) begin
        bit         take;
        frac_pair_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            take = s_tvalid && s_tready;
            if (take) begin
                expected_fracs.push_back(combine_fracs(pending_items[0]));
                void'(pending_items.pop_front());
            end
            if (!s_tvalid || take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && expected_fracs.size() > 0)) begin
                    nxt = pending_items[0];
                    s_tdata  <= {nxt.b_den, nxt.b_num, nxt.a_den, nxt.a_num};
                    s_tuser  <= nxt.func;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1500);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                    if (pending_items.size() == 0) stim_done = 1'b1;
                end
            end
        end
    end

    // Monitor: stall on a changing pattern, check each result item
    always @(posedge aclk) begin
        frac_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            cycle_count++;
            if (cycle_count % 512 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (cycle_count % 8) == 0;
                default: m_tready <= $urandom_range(0, 15) > 12;
            endcase
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_fracs.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result num=%0d den=%0d ovf=%0b", $time,
                             $signed(m_tdata[31:0]), m_tdata[62:32], m_tuser);
                end else begin
                    exp_r = expected_fracs.pop_front();
                    if (exp_r.ovf) ovf_count++;
                    if (m_tdata[31:0] !== exp_r.num || m_tdata[62:32] !== exp_r.den ||
                        m_tuser !== exp_r.ovf) begin
                        error_count++;
                        $display("%0t: mismatch expected %0d/%0d ovf=%0b actual %0d/%0d ovf=%0b",
                                 $time, $signed(exp_r.num), exp_r.den, exp_r.ovf,
                                 $signed(m_tdata[31:0]), m_tdata[62:32], m_tuser);
                    end
                end
            end
            if (idle_cycles >= StallLimit) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // End of run: drain, allow trailing latency, report
    initial begin
        wait (stim_done && expected_fracs.size() == 0);
        repeat (2000) @(posedge aclk);
        $display("Checked %0d add/multiply results (%0d overflow) under bursty input",
                 result_count, ovf_count);
        $display("and a patterned result stall, with several full drains mid-run.");
        if (error_count == 0 && expected_fracs.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
